FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Beat structs, per-cell entry and control types, status and kind codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_priority;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] prio;
  } entry_t;

  // Qualified operation broadcast to every cell.
  typedef struct packed {
    logic ins;   // insert that fits
    logic rem;   // remove from a non-empty queue
  } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds an entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    fresh,
  input  spq_pkg::entry_t    left,
  input  spq_pkg::entry_t    right,
  input  logic               left_keep,
  input  logic               occupied,
  output spq_pkg::entry_t    held,
  output logic               keep
);
  import spq_pkg::*;

  // Ties stay ahead of the new entry, so equal priorities leave in order.
  assign keep = occupied && !(held.prio < fresh.prio);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        held <= left_keep ? fresh : left;
      end
    end else if (ctrl.rem) begin
      held <= right;
    end
  end

endmodule

FILE: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-register priority queue
// Entries kept sorted by descending signed priority in a chain of cells;
// insert or remove-highest, one response beat per request beat.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | beat  | role
//   ---------+----------------------+-------+--------------------------------
//   req      | req_valid/req_stall  | req_t | insert or remove-highest
//   rsp      | rsp_valid/rsp_stall  | rsp_t | status, removed entry, count
//
// One request per cycle while req is not stalled: every cell compares its
// priority with the new one in parallel and shifts in the same edge.
// The only limit is the single response register; req stalls only while
// a response is held and rsp_stall is high.
// Reset clears the entry count and the response valid; cell contents are
// don't-care and only slots below the count are ever read.
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  entry_t           fresh;
  entry_t           held  [DEPTH];
  logic             keep  [DEPTH];
  rsp_t             rsp_next;

  // Response register frees up when it is empty or being taken this edge.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  assign ctrl.ins = accept && (req.kind == KIND_INSERT) && !full;
  assign ctrl.rem = accept && (req.kind == KIND_REMOVE) && !empty;

  assign fresh.val  = req.item_value;
  assign fresh.prio = req.item_priority;

  // Chain: cell 0 is the head. Left of cell 0 always "keeps" so it pulls
  // the fresh entry; right of the tail is a don't-care (slot becomes free).
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .fresh     (fresh),
        .left      (fresh),
        .right     (held[1]),
        .left_keep (1'b1),
        .occupied  (count > CNT_W'(i)),
        .held      (held[i]),
        .keep      (keep[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .fresh     (fresh),
        .left      (held[i-1]),
        .right     (held[i]),
        .left_keep (keep[i-1]),
        .occupied  (count > CNT_W'(i)),
        .held      (held[i]),
        .keep      (keep[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .fresh     (fresh),
        .left      (held[i-1]),
        .right     (held[i+1]),
        .left_keep (keep[i-1]),
        .occupied  (count > CNT_W'(i)),
        .held      (held[i]),
        .keep      (keep[i])
      );
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  // Response beat built from the pre-shift head.
  always_comb begin
    rsp_next.status           = ST_OK;
    rsp_next.removed_value    = '0;
    rsp_next.removed_priority = '0;
    rsp_next.entry_count      = 7'(count_next);
    if (req.kind == KIND_INSERT) begin
      if (full) begin
        rsp_next.status = ST_OVERFLOW;
      end
    end else if (empty) begin
      rsp_next.status = ST_UNDERFLOW;
    end else begin
      rsp_next.removed_value    = held[0].val;
      rsp_next.removed_priority = held[0].prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // -------------------------------------------------------------- checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove in one cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("count moved without a request");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    accept && req.kind == KIND_INSERT && full |=>
      rsp.status == ST_OVERFLOW && rsp.entry_count == 7'(DEPTH))
    else $error("overflow beat mismatch");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    accept && req.kind == KIND_REMOVE && empty |=>
      rsp.status == ST_UNDERFLOW && rsp.entry_count == 7'd0)
    else $error("underflow beat mismatch");

endmodule

FILE: bench/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the priority queue
// Drives insert/remove beats through a valid/stall port with random bursts
// and receiver stalls, mirrors the sorted store in a behavioral copy, and
// compares every response beat field by field in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // No-progress limit: set well above the longest receiver hold.
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_TAIL = 4;   // response register, plus margin
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  always #6 clk = ~clk;

  sorted_priority_queue uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // --------------------------------------------------------------------------
  // Behavioral copy of the store: slot 0 is the head, priorities never
  // increase toward the tail. Only slots below held_count are meaningful.
  // --------------------------------------------------------------------------
  logic signed [31:0] held_val [DEPTH];
  logic signed [31:0] held_pri [DEPTH];
  int   held_count = 0;

  rsp_t awaited_rsp [$];   // predicted response beats, oldest first
  int   errors = 0;

  // Receiver behavior, set by the tests.
  int stall_pct = 0;       // chance that a new run is a stall run
  int stall_run_max = 1;   // longest run of equal rsp_stall
  int hold_len = 0;        // one-shot long hold request, in cycles

  // Apply one accepted request to the copy and return the beat it causes.
  function automatic rsp_t predict_pq_op(req_t r);
    rsp_t o;
    int   pos;
    o = '0;
    o.status = ST_OK;
    if (r.kind == KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        o.status = ST_OVERFLOW;
      end else begin
        // New entry goes behind every entry of greater or equal priority.
        pos = held_count;
        while (pos > 0 && $signed(held_pri[pos-1]) < $signed(r.item_priority)) begin
          held_val[pos] = held_val[pos-1];
          held_pri[pos] = held_pri[pos-1];
          pos--;
        end
        held_val[pos] = r.item_value;
        held_pri[pos] = r.item_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        o.status = ST_UNDERFLOW;
      end else begin
        o.removed_value    = held_val[0];
        o.removed_priority = held_pri[0];
        for (int k = 1; k < held_count; k++) begin
          held_val[k-1] = held_val[k];
          held_pri[k-1] = held_pri[k];
        end
        held_count--;
      end
    end
    o.entry_count = held_count[6:0];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at the falling edge after the
  // beat was taken, with req_valid still high so back-to-back beats never
  // lower and raise valid in one step. Gaps lower it in pause().
  // --------------------------------------------------------------------------
  task automatic send_op(input logic kind, input logic [31:0] value,
                         input logic [31:0] prio);
    req_t r;
    r.kind          = kind;
    r.item_value    = value;
    r.item_priority = prio;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    awaited_rsp.push_back(predict_pq_op(r));
    @(negedge clk);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      if (req_valid) req_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Sender stops until every predicted beat has come back.
  task automatic wait_drain();
    if (req_valid) req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
  endtask

  // Priorities: often a narrow band so ties are common, plus the extremes and full-range values.
  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4, 5: return $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic in bursts; ins_pct biases occupancy up or down.
  task automatic run_random(input int count, input int ins_pct, input int gap_max);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        pause($urandom_range(0, gap_max));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_op(($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE,
              $urandom, rand_prio());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Remove from an empty queue, twice in a row.
  task automatic test_empty_remove();
    stall_pct = 0;
    send_op(KIND_REMOVE, $urandom, $urandom);
    send_op(KIND_REMOVE, $urandom, $urandom);
  endtask

  // Extreme values and priorities, ties at top, middle and bottom,
  // then drain past empty.
  task automatic test_priority_extremes();
    stall_pct = 30;
    stall_run_max = 3;
    send_op(KIND_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0000, 32'h8000_0000);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);  // tie, behind first
    pause(2);
    send_op(KIND_INSERT, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0002, 32'h7FFF_FFFF);  // tie at the head
    send_op(KIND_INSERT, 32'h0000_0003, 32'h8000_0000);  // tie at the tail
    pause(1);
    repeat (8) send_op(KIND_REMOVE, $urandom, $urandom);  // last one underflows
  endtask

  // Fill to capacity, push past it, then empty it and push past that.
  task automatic test_fill_overflow();
    stall_pct = 40;
    stall_run_max = 6;
    run_random(DEPTH + 3, 100, 3);
    run_random(DEPTH + 3, 0, 3);
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering back to back,
  // so the output register fills and req_stall rises.
  task automatic test_backpressure();
    wait_drain();
    stall_pct = 0;
    hold_len = 300;
    for (int i = 0; i < 30; i++) begin
      send_op(($urandom_range(0, 3) != 0) ? KIND_INSERT : KIND_REMOVE,
              $urandom, rand_prio());
    end
    wait_drain();
  endtask

  // Mixed traffic with occupancy drifting between full and empty.
  task automatic test_random_mix();
    stall_pct = 30;  stall_run_max = 5;
    run_random(100, 70, 4);
    stall_pct = 0;   stall_run_max = 1;   // no idling on either side
    run_random(100, 50, 0);
    stall_pct = 60;  stall_run_max = 10;
    run_random(100, 35, 8);
    stall_pct = 20;  stall_run_max = 4;
    run_random(40, 90, 2);
    run_random(40, 15, 2);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: runs of stall/no-stall of random length, or a one-shot
  // long hold counted here.
  // --------------------------------------------------------------------------
  initial begin
    int  run_left;
    int  n;
    logic stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 99) < stall_pct);
          run_left  = $urandom_range(1, stall_run_max);
        end
        run_left--;
        rsp_stall <= stall_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response check and no-progress watchdog, both at the rising edge.
  // --------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    if (awaited_rsp.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: response beat with none expected, actual %p", $time, got);
      return;
    end
    want = awaited_rsp.pop_front();
    cmp_field("status", 32'(want.status), 32'(got.status));
    cmp_field("removed_value", want.removed_value, got.removed_value);
    cmp_field("removed_priority", want.removed_priority, got.removed_priority);
    cmp_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
  endtask

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) check_rsp(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_remove();
    test_priority_extremes();
    test_fill_overflow();
    test_backpressure();
    test_random_mix();

    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0 && awaited_rsp.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
bench/sorted_priority_queue_test.sv
